### rtl/core/rgps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgps_pkg
// Shared types and constants for the radius graph pair scan.
// ----------------------------------------------------------------------------
package rgps_pkg;

    localparam int NCELL     = 2;
    localparam int TAGW      = 1;
    localparam int DATA_W    = 16;
    localparam int DIST_W    = 40;
    localparam int ECNT_W    = 15;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 16;
    localparam int DRAIN     = NCELL + 5;
    localparam int DRAIN_W   = 4;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [CFG_AW-1:0] {
        REG_GRAPH_KIND  = 2'd0,
        REG_RESPONDENTS = 2'd1,
        REG_ITEMS       = 2'd2,
        REG_RADIUS      = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_SUM,
        ST_THR,
        ST_RES
    } t_state;

endpackage

### rtl/core/rgps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgps_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rgps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/core/rgps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgps_cell
// Chain cell: passes element pairs on and sums squared differences of its own.
// ----------------------------------------------------------------------------
module rgps_cell #(
    parameter int IDX = 0,
    parameter int SW  = 41
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  logic                              i_vld,
    input  logic [rgps_pkg::TAGW-1:0]         i_tag,
    input  logic signed [rgps_pkg::DATA_W-1:0] i_a,
    input  logic signed [rgps_pkg::DATA_W-1:0] i_b,
    output logic                              o_vld,
    output logic [rgps_pkg::TAGW-1:0]         o_tag,
    output logic signed [rgps_pkg::DATA_W-1:0] o_a,
    output logic signed [rgps_pkg::DATA_W-1:0] o_b,
    output logic [SW-1:0]                     o_acc
);
    import rgps_pkg::*;

    logic                    w_take;
    logic                    r_d_vld;
    logic signed [DATA_W:0]  r_d;
    logic signed [DATA_W:0]  w_neg;
    logic [DATA_W-1:0]       w_mag;
    logic                    r_sq_vld;
    logic [2*DATA_W-1:0]     r_sq;
    logic [SW-1:0]           r_acc;

    assign w_take = i_vld && (i_tag == TAGW'(IDX));
    assign w_neg  = -r_d;
    assign w_mag  = r_d[DATA_W] ? w_neg[DATA_W-1:0] : r_d[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld    <= 1'b0;
            r_d_vld  <= 1'b0;
            r_sq_vld <= 1'b0;
            r_acc    <= '0;
        end else begin
            o_vld    <= i_vld;
            r_d_vld  <= w_take;
            r_sq_vld <= r_d_vld;
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_sq_vld) begin
                r_acc <= r_acc + SW'(r_sq);
            end
        end
        o_tag <= i_tag;
        o_a   <= i_a;
        o_b   <= i_b;
        r_d   <= (DATA_W+1)'(i_a) - (DATA_W+1)'(i_b);
        r_sq  <= (2*DATA_W)'(w_mag) * (2*DATA_W)'(w_mag);
    end

    assign o_acc = r_acc;

endmodule

### rtl/core/radius_graph_pair_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radius_graph_pair_scan
// Loads a response matrix and scores one row or column pair per advance.
// ----------------------------------------------------------------------------
// A load transaction runs the bit-serial divider that maps the load position to
// row and column, then writes the response into the RAM. An advance
// transaction that scores a pair reads one element pair per scan step
// through the two RAM read ports into the cell chain; the result waits
// in an output register while the next transaction is taken. An advance
// past the end of the scan is taken in the idle state without scoring.
module radius_graph_pair_scan #(
    parameter int MAX_RESPONDENTS = 256,
    parameter int MAX_ITEMS       = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rgps_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [rgps_pkg::CFG_DW-1:0]      i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_mode,
    input  logic signed [15:0]               i_response,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [7:0]                       o_first_index,
    output logic [7:0]                       o_second_index,
    output logic [rgps_pkg::DIST_W-1:0]      o_distance_squared,
    output logic                             o_is_edge,
    output logic [rgps_pkg::ECNT_W-1:0]      o_edge_count,
    output logic                             o_last
);
    import rgps_pkg::*;

    localparam int DEPTH = MAX_RESPONDENTS * MAX_ITEMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int MAXC  = (MAX_RESPONDENTS > MAX_ITEMS) ? MAX_RESPONDENTS : MAX_ITEMS;
    localparam int XW    = $clog2(MAXC + 1);
    localparam int TW    = 2 * XW;
    localparam int SW    = 33 + $clog2(MAXC);
    localparam int HW    = 32 + XW;
    localparam int EW    = (SW + 4 > HW) ? SW + 4 : HW;
    localparam int SCW   = $clog2(PW + 1);
    localparam logic [AW-1:0] STRIDE = AW'(MAX_ITEMS);

    t_state             r_state, n_state;
    logic               r_kind;
    logic [8:0]         r_resp_cfg;
    logic [6:0]         r_items_cfg;
    logic [15:0]        r_radius;

    logic [XW-1:0]      w_resp, w_items, w_count, w_dim;
    logic [TW-1:0]      w_total;
    logic [PW-1:0]      w_pos_eff, w_pos_inc;
    logic [PW-1:0]      r_pos, r_dq;
    logic [XW-1:0]      r_rem;
    logic [XW:0]        w_rem_sh;
    logic               w_qbit;
    logic [SCW-1:0]     r_step;
    logic [DATA_W-1:0]  r_wdata;
    logic               w_we;
    logic [AW-1:0]      w_waddr;

    logic [XW-1:0]      r_first, r_second, r_dim;
    logic               r_done, r_clr;
    logic [AW-1:0]      r_addr_a, r_addr_b, r_inc;
    logic [XW-1:0]      r_k;
    logic [TAGW-1:0]    r_tag, r_iss_tag;
    logic               r_iss_vld;
    logic [DRAIN_W-1:0] r_drain;
    logic [DATA_W-1:0]  w_rd_a, w_rd_b;

    logic               w_vld [NCELL+1];
    logic [TAGW-1:0]    w_tag [NCELL+1];
    logic signed [DATA_W-1:0] w_a [NCELL+1];
    logic signed [DATA_W-1:0] w_b [NCELL+1];
    logic [SW-1:0]      w_acc [NCELL];
    logic [SW-1:0]      w_acc_sum;

    logic [SW-1:0]      r_sum;
    logic [31:0]        r_rr;
    logic [HW-1:0]      r_thr;
    logic               w_edge, w_last, w_bad, w_out_free;
    logic [ECNT_W-1:0]  r_edges;

    // ---- clamped counts
    always_comb begin
        if (r_resp_cfg < 9'd2) begin
            w_resp = XW'(2);
        end else if (32'(r_resp_cfg) > MAX_RESPONDENTS) begin
            w_resp = XW'(MAX_RESPONDENTS);
        end else begin
            w_resp = XW'(r_resp_cfg);
        end
        if (r_items_cfg < 7'd2) begin
            w_items = XW'(2);
        end else if (32'(r_items_cfg) > MAX_ITEMS) begin
            w_items = XW'(MAX_ITEMS);
        end else begin
            w_items = XW'(r_items_cfg);
        end
    end

    assign w_count   = r_kind ? w_items : w_resp;
    assign w_dim     = r_kind ? w_resp : w_items;
    assign w_total   = TW'(w_resp) * TW'(w_items);
    assign w_pos_eff = (32'(r_pos) >= 32'(w_total)) ? '0 : r_pos;
    assign w_pos_inc = r_pos + PW'(1);
    assign w_rem_sh  = {r_rem, r_dq[PW-1]};
    assign w_qbit    = w_rem_sh >= (XW+1)'(w_items);
    assign w_we      = (r_state == ST_WR);
    assign w_waddr   = AW'(AW'(r_dq) * STRIDE + AW'(r_rem));

    assign w_bad = r_done || (r_second >= w_count) || (r_first >= r_second);
    assign w_last = ((XW+1)'(r_first) + (XW+1)'(2) == (XW+1)'(w_count)) &&
                    ((XW+1)'(r_second) + (XW+1)'(1) == (XW+1)'(w_count));
    assign w_edge = EW'({r_sum, 4'b0000}) < EW'(r_thr);
    assign w_out_free = !o_valid || !i_stall;
    assign o_stall = (r_state != ST_IDLE);

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= 1'b0;
            r_resp_cfg  <= 9'd256;
            r_items_cfg <= 7'd64;
            r_radius    <= 16'd18350;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_GRAPH_KIND:  r_kind      <= i_cfg_data[0];
                REG_RESPONDENTS: r_resp_cfg  <= i_cfg_data[8:0];
                REG_ITEMS:       r_items_cfg <= i_cfg_data[6:0];
                REG_RADIUS:      r_radius    <= i_cfg_data;
                default:         r_kind      <= r_kind;
            endcase
        end
    end

    // ---- state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!i_mode) begin
                        n_state = ST_DIV;
                    end else if (!w_bad) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_DIV:   if (r_step == SCW'(PW - 1)) n_state = ST_WR;
            ST_WR:    n_state = ST_IDLE;
            ST_SCAN:  if (r_k == r_dim - XW'(1)) n_state = ST_DRAIN;
            ST_DRAIN: if (r_drain == DRAIN_W'(DRAIN - 1)) n_state = ST_SUM;
            ST_SUM:   n_state = ST_THR;
            ST_THR:   n_state = ST_RES;
            ST_RES:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---- control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_first   <= '0;
            r_second  <= XW'(1);
            r_done    <= 1'b0;
            r_edges   <= '0;
            r_clr     <= 1'b0;
            r_iss_vld <= 1'b0;
            r_step    <= '0;
            r_drain   <= '0;
            r_k       <= '0;
            r_tag     <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_clr     <= 1'b0;
            r_iss_vld <= (r_state == ST_SCAN);
            if (o_valid && !i_stall && !((r_state == ST_RES) && w_out_free)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_step  <= '0;
                    r_drain <= '0;
                    r_k     <= '0;
                    r_tag   <= '0;
                    if (i_valid) begin
                        if (!i_mode) begin
                            r_pos <= w_pos_eff;
                        end else if (w_bad) begin
                            r_done <= 1'b1;
                        end else begin
                            r_clr <= 1'b1;
                        end
                    end
                end
                ST_DIV: r_step <= r_step + SCW'(1);
                ST_WR: begin
                    r_pos <= (32'(w_pos_inc) >= 32'(w_total)) ? '0 : w_pos_inc;
                end
                ST_SCAN: begin
                    r_k   <= r_k + XW'(1);
                    r_tag <= (r_tag == TAGW'(NCELL - 1)) ? '0 : r_tag + TAGW'(1);
                end
                ST_DRAIN: r_drain <= r_drain + DRAIN_W'(1);
                ST_SUM, ST_THR: r_step <= r_step;
                ST_RES: begin
                    if (w_out_free) begin
                        o_valid <= 1'b1;
                        if (w_edge && (r_edges != '1)) begin
                            r_edges <= r_edges + ECNT_W'(1);
                        end
                        if (w_last) begin
                            r_done <= 1'b1;
                        end else if (r_second + XW'(1) >= w_count) begin
                            r_first  <= r_first + XW'(1);
                            r_second <= r_first + XW'(2);
                        end else begin
                            r_second <= r_second + XW'(1);
                        end
                    end
                end
                default: r_step <= r_step;
            endcase
        end
    end

    // ---- payload registers
    always_ff @(posedge i_clk) begin
        r_iss_tag <= r_tag;
        if (r_state == ST_IDLE) begin
            r_wdata  <= i_response;
            r_dq     <= w_pos_eff;
            r_rem    <= '0;
            r_dim    <= w_dim;
            r_addr_a <= r_kind ? AW'(r_first) : AW'(AW'(r_first) * STRIDE);
            r_addr_b <= r_kind ? AW'(r_second) : AW'(AW'(r_second) * STRIDE);
            r_inc    <= r_kind ? STRIDE : AW'(1);
        end
        if (r_state == ST_DIV) begin
            r_dq  <= {r_dq[PW-2:0], w_qbit};
            r_rem <= w_qbit ? XW'(w_rem_sh - (XW+1)'(w_items)) : XW'(w_rem_sh);
        end
        if (r_state == ST_SCAN) begin
            r_addr_a <= r_addr_a + r_inc;
            r_addr_b <= r_addr_b + r_inc;
        end
        if (r_state == ST_SUM) begin
            r_sum <= w_acc_sum;
            r_rr  <= 32'(r_radius) * 32'(r_radius);
        end
        if (r_state == ST_THR) begin
            r_thr <= HW'(r_rr) * HW'(r_dim);
        end
        if ((r_state == ST_RES) && w_out_free) begin
            o_first_index      <= 8'(r_first);
            o_second_index     <= 8'(r_second);
            o_distance_squared <= (64'(r_sum) > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(r_sum);
            o_is_edge          <= w_edge;
            o_edge_count       <= (w_edge && (r_edges != '1)) ? r_edges + ECNT_W'(1)
                                                              : r_edges;
            o_last             <= w_last;
        end
    end

    // ---- response store
    rgps_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (r_wdata),
        .i_raddr_a (r_addr_a),
        .i_raddr_b (r_addr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // ---- cell chain
    assign w_vld[0] = r_iss_vld;
    assign w_tag[0] = r_iss_tag;
    assign w_a[0]   = w_rd_a;
    assign w_b[0]   = w_rd_b;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        rgps_cell #(
            .IDX (g),
            .SW  (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (r_clr),
            .i_vld   (w_vld[g]),
            .i_tag   (w_tag[g]),
            .i_a     (w_a[g]),
            .i_b     (w_b[g]),
            .o_vld   (w_vld[g+1]),
            .o_tag   (w_tag[g+1]),
            .o_a     (w_a[g+1]),
            .o_b     (w_b[g+1]),
            .o_acc   (w_acc[g])
        );
    end

    always_comb begin
        w_acc_sum = '0;
        for (int i = 0; i < NCELL; i++) begin
            w_acc_sum = w_acc_sum + w_acc[i];
        end
    end

`ifndef ASSERT_OFF
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first < r_second) else $error("pair order broken");
    a_edges_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edges >= $past(r_edges)) else $error("edge count went down");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> r_done) else $error("scan not closed on last pair");
    a_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_vld[NCELL] && !r_iss_vld)
        else $error("cell chain busy while idle");
`endif

endmodule
